// ===== sv/tftp_receive_packet_checker_core_macros.svh =====
// ----------------------------------------------------------------------------
// TFTP receive packet checker: assertion macros
// Concurrent assertion wrappers on clk_i / rst_ni; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef TFTP_RECEIVE_PACKET_CHECKER_CORE_MACROS_SVH
`define TFTP_RECEIVE_PACKET_CHECKER_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle or implication property, disabled during reset
`define TRPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// antecedent in one cycle, consequent in the next
`define TRPC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) \
    else $error(msg);
`else
`define TRPC_ASSERT(label, prop, msg)
`define TRPC_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// ===== sv/tftp_rpc_pkg.sv =====
// ----------------------------------------------------------------------------
// TFTP receive packet checker: package
// Verdict and parser phase codes, protocol constants and the per-packet
// parser status passed to the verdict logic.
// ----------------------------------------------------------------------------
package tftp_rpc_pkg;

  typedef enum logic [3:0] {
    V_OK          = 4'd0,
    V_COMPLETE    = 4'd1,
    V_DUPLICATE   = 4'd2,
    V_OUT_OF_ORD  = 4'd3,
    V_CAPACITY    = 4'd4,
    V_MALFORMED   = 4'd5,
    V_UNSUP_OPT   = 4'd6,
    V_REMOTE_ERR  = 4'd7,
    V_INVALID     = 4'd8
  } verdict_e;

  typedef enum logic [3:0] {
    PH_NAME  = 4'b0001,
    PH_VALUE = 4'b0010,
    PH_DONE  = 4'b0100,
    PH_EXTRA = 4'b1000
  } phase_e;

  localparam logic [15:0] OP_DATA  = 16'd3;
  localparam logic [15:0] OP_ERROR = 16'd5;
  localparam logic [15:0] OP_OACK  = 16'd6;

  localparam logic [10:0] BLK_MIN = 11'd512;
  localparam logic [10:0] BLK_MAX = 11'd1468;

  localparam logic [1:0] CFG_REQ_BLK = 2'd0;
  localparam logic [1:0] CFG_BUDGET  = 2'd1;

  // option name length; name_len saturates one above it
  localparam logic [3:0] OPT_LEN     = 4'd7;
  localparam logic [3:0] OPT_LEN_SAT = 4'd8;
  // most value digits; digit count saturates one above it
  localparam logic [2:0] DIG_MAX     = 3'd5;
  localparam logic [2:0] DIG_SAT     = 3'd6;

  typedef struct packed {
    logic [15:0] pos;        // byte position before this byte
    logic [15:0] opcode;
    logic [15:0] block;
    phase_e      phase;
    logic [3:0]  name_len;
    logic        name_match;
    logic [15:0] dig_val;
    logic [2:0]  dig_cnt;
    logic        val_ok;
  } pkt_info_t;

  // lower-case "blksize"
  function automatic logic [7:0] opt_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h62;
      3'd1:    c = 8'h6C;
      3'd2:    c = 8'h6B;
      3'd3:    c = 8'h73;
      3'd4:    c = 8'h69;
      3'd5:    c = 8'h7A;
      3'd6:    c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/tftp_rpc_parse.sv =====
// ----------------------------------------------------------------------------
// TFTP receive packet checker: byte parser
// Tracks position, opcode and block fields and the single-option parse of
// the current packet; presents the status including the current word, except pos.
// ----------------------------------------------------------------------------
module tftp_rpc_parse (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   restart_i,
  input  logic                   byte_en_i,
  input  logic [7:0]             packet_byte_i,
  input  logic                   last_byte_i,
  output tftp_rpc_pkg::pkt_info_t info_o
);
  import tftp_rpc_pkg::*;

  logic [15:0] pos_q, pos_d;
  logic [15:0] opcode_q, opcode_d;
  logic [15:0] block_q, block_d;
  phase_e      phase_q, phase_d;
  logic [3:0]  name_len_q, name_len_d;
  logic        name_match_q, name_match_d;
  logic [15:0] dig_val_q, dig_val_d;
  logic [2:0]  dig_cnt_q, dig_cnt_d;
  logic        val_ok_q, val_ok_d;

  logic [7:0]  lc;
  logic [3:0]  digit;
  logic [19:0] acc;

  always_comb begin
    pos_d        = (pos_q == 16'hFFFF) ? pos_q : pos_q + 16'd1;
    opcode_d     = opcode_q;
    block_d      = block_q;
    phase_d      = phase_q;
    name_len_d   = name_len_q;
    name_match_d = name_match_q;
    dig_val_d    = dig_val_q;
    dig_cnt_d    = dig_cnt_q;
    val_ok_d     = val_ok_q;
    lc           = (packet_byte_i >= 8'h41 && packet_byte_i <= 8'h5A) ?
                   packet_byte_i + 8'd32 : packet_byte_i;
    digit        = packet_byte_i[3:0];
    acc          = {dig_val_q, 3'b000} + {3'b000, dig_val_q, 1'b0} + {16'd0, digit};

    if (pos_q == 16'd0) begin
      opcode_d = {packet_byte_i, 8'h00};
    end else if (pos_q == 16'd1) begin
      opcode_d = {opcode_q[15:8], packet_byte_i};
    end else begin
      if (pos_q == 16'd2) begin
        block_d = {packet_byte_i, 8'h00};
      end else if (pos_q == 16'd3) begin
        block_d = {block_q[15:8], packet_byte_i};
      end
      case (phase_q)
        PH_NAME: begin
          if (packet_byte_i == 8'h00) begin
            phase_d = PH_VALUE;
          end else begin
            if (name_len_q < OPT_LEN) begin
              if (lc != opt_char(name_len_q[2:0])) name_match_d = 1'b0;
            end else begin
              name_match_d = 1'b0;
            end
            if (name_len_q != OPT_LEN_SAT) name_len_d = name_len_q + 4'd1;
          end
        end
        PH_VALUE: begin
          if (packet_byte_i == 8'h00) begin
            phase_d = PH_DONE;
          end else begin
            if (packet_byte_i < 8'h30 || packet_byte_i > 8'h39) begin
              val_ok_d = 1'b0;
            end else if (val_ok_q) begin
              if (acc > 20'd65535) val_ok_d = 1'b0;
              else dig_val_d = acc[15:0];
            end
            if (dig_cnt_q != DIG_SAT) dig_cnt_d = dig_cnt_q + 3'd1;
          end
        end
        default: begin
          phase_d = PH_EXTRA;
        end
      endcase
    end
  end

  always_comb begin
    info_o.pos        = pos_q;
    info_o.opcode     = opcode_d;
    info_o.block      = block_d;
    info_o.phase      = phase_d;
    info_o.name_len   = name_len_d;
    info_o.name_match = name_match_d;
    info_o.dig_val    = dig_val_d;
    info_o.dig_cnt    = dig_cnt_d;
    info_o.val_ok     = val_ok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      opcode_q     <= '0;
      block_q      <= '0;
      phase_q      <= PH_NAME;
      name_len_q   <= '0;
      name_match_q <= 1'b1;
      dig_val_q    <= '0;
      dig_cnt_q    <= '0;
      val_ok_q     <= 1'b1;
    end else if (restart_i || (byte_en_i && last_byte_i)) begin
      pos_q        <= '0;
      opcode_q     <= '0;
      block_q      <= '0;
      phase_q      <= PH_NAME;
      name_len_q   <= '0;
      name_match_q <= 1'b1;
      dig_val_q    <= '0;
      dig_cnt_q    <= '0;
      val_ok_q     <= 1'b1;
    end else if (byte_en_i) begin
      pos_q        <= pos_d;
      opcode_q     <= opcode_d;
      block_q      <= block_d;
      phase_q      <= phase_d;
      name_len_q   <= name_len_d;
      name_match_q <= name_match_d;
      dig_val_q    <= dig_val_d;
      dig_cnt_q    <= dig_cnt_d;
      val_ok_q     <= val_ok_d;
    end
  end

endmodule

// ===== sv/tftp_receive_packet_checker_core.sv =====
// ----------------------------------------------------------------------------
// TFTP receive packet checker
// Takes one packet byte per cycle (one word per clock) and, on the word
// marked last, registers one verdict for the packet: the whole check of a
// byte sits between the parser state and the result register, so the input
// stays ready every cycle unless a verdict waits in the result register
// and is not being taken. The verdict appears the cycle after the last byte.
// A blksize or budget write restarts the transfer, dropping a partial packet.
// ----------------------------------------------------------------------------
`include "tftp_receive_packet_checker_core_macros.svh"

module tftp_receive_packet_checker_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [31:0]               cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                packet_byte_i,
  input  logic                      last_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output tftp_rpc_pkg::verdict_e    verdict_o,
  output logic                      payload_valid_o,
  output logic [10:0]               payload_length_o,
  output logic [15:0]               block_number_o
);
  import tftp_rpc_pkg::*;

  function automatic logic [10:0] clamp_blk(input logic [10:0] r);
    logic [10:0] c;
    c = r;
    if (r < BLK_MIN) c = BLK_MIN;
    if (r > BLK_MAX) c = BLK_MAX;
    return c;
  endfunction

  logic [10:0] req_blk_q;
  logic [31:0] budget_q;
  logic [15:0] next_blk_q;
  logic [10:0] active_q;
  logic        opts_done_q;
  logic        xfer_done_q;
  logic [31:0] bytes_q;
  logic [15:0] pkts_q;

  logic        out_valid_q;
  verdict_e    verdict_q, verdict_d;
  logic        pay_valid_q, pay_valid_d;
  logic [10:0] pay_len_q, pay_len_d;
  logic [15:0] blk_q, blk_d;

  logic        in_fire, res_fire, restart;
  logic [10:0] new_req;
  pkt_info_t   info;
  logic [16:0] data;
  logic [31:0] room;
  logic        oack_acc, data_acc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign res_fire   = in_fire && last_byte_i;
  assign restart    = cfg_we_i && (cfg_idx_i == CFG_REQ_BLK || cfg_idx_i == CFG_BUDGET);
  assign new_req    = (cfg_idx_i == CFG_REQ_BLK) ? cfg_wdata_i[10:0] : req_blk_q;

  tftp_rpc_parse u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .restart_i     (restart),
    .byte_en_i     (in_fire),
    .packet_byte_i (packet_byte_i),
    .last_byte_i   (last_byte_i),
    .info_o        (info)
  );

  assign data = {1'b0, info.pos} - 17'd3;
  assign room = budget_q - bytes_q;

  always_comb begin
    verdict_d   = V_MALFORMED;
    pay_valid_d = 1'b0;
    pay_len_d   = '0;
    blk_d       = '0;
    oack_acc    = 1'b0;
    data_acc    = 1'b0;
    if (xfer_done_q || info.pos == 16'd0 || pkts_q == 16'hFFFF) begin
      verdict_d = V_INVALID;
    end else if (info.pos == 16'hFFFF) begin
      verdict_d = V_MALFORMED;
    end else if (info.opcode == OP_OACK) begin
      if (opts_done_q || next_blk_q != 16'd1 || info.pos < 16'd5) begin
        verdict_d = V_MALFORMED;
      end else if (info.phase == PH_NAME || info.name_len != OPT_LEN ||
                   !info.name_match) begin
        verdict_d = V_UNSUP_OPT;
      end else if (info.phase != PH_DONE || info.dig_cnt == 3'd0 ||
                   info.dig_cnt > DIG_MAX || !info.val_ok ||
                   info.dig_val < {5'd0, BLK_MIN} || info.dig_val > {5'd0, BLK_MAX} ||
                   info.dig_val > {5'd0, active_q}) begin
        verdict_d = V_MALFORMED;
      end else begin
        verdict_d = V_OK;
        oack_acc  = 1'b1;
      end
    end else if (info.opcode == OP_ERROR) begin
      verdict_d = (info.pos >= 16'd4) ? V_REMOTE_ERR : V_MALFORMED;
    end else if (info.opcode != OP_DATA || info.pos < 16'd3) begin
      verdict_d = V_MALFORMED;
    end else begin
      blk_d = info.block;
      if (data > {6'd0, active_q}) begin
        verdict_d = V_MALFORMED;
      end else if (next_blk_q > 16'd1 && info.block == next_blk_q - 16'd1) begin
        verdict_d = V_DUPLICATE;
      end else if (info.block != next_blk_q || next_blk_q == 16'hFFFF) begin
        verdict_d = V_OUT_OF_ORD;
      end else if ({15'd0, data} > room) begin
        verdict_d = V_CAPACITY;
      end else begin
        data_acc    = 1'b1;
        pay_valid_d = 1'b1;
        pay_len_d   = data[10:0];
        verdict_d   = (data[10:0] < active_q) ? V_COMPLETE : V_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_blk_q   <= BLK_MIN;
      budget_q    <= 32'hFFFF_FFFF;
      next_blk_q  <= 16'd1;
      active_q    <= BLK_MIN;
      opts_done_q <= 1'b0;
      xfer_done_q <= 1'b0;
      bytes_q     <= '0;
      pkts_q      <= '0;
    end else if (restart) begin
      if (cfg_idx_i == CFG_REQ_BLK) req_blk_q <= cfg_wdata_i[10:0];
      if (cfg_idx_i == CFG_BUDGET)  budget_q  <= cfg_wdata_i;
      next_blk_q  <= 16'd1;
      active_q    <= clamp_blk(new_req);
      opts_done_q <= 1'b0;
      xfer_done_q <= 1'b0;
      bytes_q     <= '0;
      pkts_q      <= '0;
    end else if (res_fire) begin
      if (oack_acc) begin
        active_q    <= info.dig_val[10:0];
        opts_done_q <= 1'b1;
        pkts_q      <= pkts_q + 16'd1;
      end
      if (data_acc) begin
        opts_done_q <= 1'b1;
        bytes_q     <= bytes_q + {15'd0, data};
        next_blk_q  <= next_blk_q + 16'd1;
        pkts_q      <= pkts_q + 16'd1;
        if (verdict_d == V_COMPLETE) xfer_done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_fire && !restart) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      verdict_q   <= verdict_d;
      pay_valid_q <= pay_valid_d;
      pay_len_q   <= pay_len_d;
      blk_q       <= blk_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign verdict_o        = verdict_q;
  assign payload_valid_o  = pay_valid_q;
  assign payload_length_o = pay_len_q;
  assign block_number_o   = blk_q;

  `TRPC_ASSERT(a_pay_verdict, out_valid_q && pay_valid_q |-> (verdict_q == V_OK || verdict_q == V_COMPLETE), "payload flagged on a rejected packet")
  `TRPC_ASSERT(a_pay_len_zero, out_valid_q && !pay_valid_q |-> pay_len_q == 11'd0, "payload length without payload")
  `TRPC_ASSERT(a_active_range, active_q >= BLK_MIN && active_q <= BLK_MAX, "active block size out of range")
  `TRPC_ASSERT(a_budget, bytes_q <= budget_q, "bytes received exceed budget")
  `TRPC_ASSERT_NEXT(a_done_invalid, res_fire && !restart && xfer_done_q, out_valid_q && verdict_q == V_INVALID, "packet after transfer end not invalid")

endmodule
